// ===== src/twec_pkg.sv =====
package twec_pkg;

    localparam int KIND_W      = 2;
    localparam int NOW_W       = 63;
    localparam int VALUE_W     = 32;
    localparam int COUNT_OUT_W = 32;
    localparam int NUMBER_W    = 32;
    localparam int CFG_LEN_W   = 40;
    localparam int CFG_DATA_W  = 63;
    localparam int CFG_INDEX_W = 2;
    localparam int S_TDATA_W   = 96;
    localparam int M_TDATA_W   = 128;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD           = 2'd0,
        KIND_SET           = 2'd1,
        KIND_READ_COUNT    = 2'd2,
        KIND_READ_INTERVAL = 2'd3
    } kind_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_LENGTH      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_WINDOW_START = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPORT_FULL_WINDOW = 2'd2;

    typedef struct packed {
        logic latch_item;
        logic calc_end;
        logic calc_gap;
        logic step_end;
        logic div_load;
        logic div_step;
        logic jump;
        logic calc_prev;
        logic classify;
        logic load_out;
    } twec_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  now_gt_end;
        logic  gap_gt_len;
    } twec_status_t;

endpackage

// ===== src/twec_datapath.sv =====
module twec_datapath
    import twec_pkg::*;
#(
    parameter int TIME_WIDTH  = 64,
    parameter int COUNT_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  twec_cmd_t                    cmd,
    output twec_status_t                 status,
    input  logic                         cfg_we,
    input  logic [CFG_INDEX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic [KIND_W-1:0]            in_kind,
    input  logic [NOW_W-1:0]             in_now,
    input  logic signed [VALUE_W-1:0]    in_value,
    output logic [COUNT_OUT_W-1:0]       reported_count,
    output logic [NOW_W-1:0]             window_start_time,
    output logic [NUMBER_W-1:0]          window_number
);

    localparam int LEN_W = (TIME_WIDTH < CFG_LEN_W) ? TIME_WIDTH : CFG_LEN_W;

    // configuration
    logic [CFG_LEN_W-1:0]         len_cfg_reg;
    logic                         report_reg;

    // counter state
    logic [TIME_WIDTH-1:0]        ws_reg;
    logic [NUMBER_W-1:0]          idx_reg;
    logic [COUNT_WIDTH-1:0]       run_reg;
    logic [COUNT_WIDTH-1:0]       last_reg;
    logic [TIME_WIDTH-1:0]        let_reg;

    // item and working registers
    kind_t                        kind_reg;
    logic [TIME_WIDTH-1:0]        now_reg;
    logic signed [VALUE_W-1:0]    value_reg;
    logic [TIME_WIDTH-1:0]        end_reg;
    logic [TIME_WIDTH-1:0]        gap_reg;
    logic                         gt_reg;
    logic [TIME_WIDTH-1:0]        prev_reg;
    logic [TIME_WIDTH-1:0]        quo_reg;
    logic [LEN_W-1:0]             rem_reg;

    logic [COUNT_OUT_W-1:0]       rep_reg;
    logic [NOW_W-1:0]             wst_reg;
    logic [NUMBER_W-1:0]          num_reg;

    logic [LEN_W-1:0]             len_trunc;
    logic [LEN_W-1:0]             len_eff;
    logic [TIME_WIDTH-1:0]        len_time;

    logic [LEN_W:0]               trial;
    logic [LEN_W:0]               diff;
    logic                         q_bit;
    logic [LEN_W-1:0]             rem_step;

    logic [COUNT_WIDTH-1:0]       run_cls;
    logic [COUNT_WIDTH-1:0]       last_cls;
    logic [COUNT_WIDTH-1:0]       run_next;
    logic [COUNT_WIDTH-1:0]       last_next;

    // a zero length behaves as one
    assign len_trunc = LEN_W'(len_cfg_reg);
    assign len_eff   = (len_trunc == '0) ? LEN_W'(1) : len_trunc;
    assign len_time  = TIME_WIDTH'(len_eff);

    // restoring division, one quotient bit per cycle; quotient builds up in quo_reg
    assign trial    = {rem_reg, quo_reg[TIME_WIDTH-1]};
    assign q_bit    = (trial >= {1'b0, len_eff});
    assign diff     = trial - {1'b0, len_eff};
    assign rem_step = q_bit ? diff[LEN_W-1:0] : trial[LEN_W-1:0];

    always_comb
    begin
        run_cls  = run_reg;
        last_cls = last_reg;
        if (let_reg < prev_reg)
        begin
            run_cls  = '0;
            last_cls = '0;
        end
        else if (let_reg < ws_reg)
        begin
            last_cls = run_reg;
            run_cls  = '0;
        end
        run_next  = run_cls;
        last_next = last_cls;
        unique case (kind_reg)
            KIND_ADD:
            begin
                run_next = run_cls + COUNT_WIDTH'(value_reg);
            end
            KIND_SET:
            begin
                last_next = COUNT_WIDTH'($unsigned(value_reg));
                run_next  = '0;
            end
            KIND_READ_COUNT, KIND_READ_INTERVAL:
            begin
                run_next  = run_cls;
                last_next = last_cls;
            end
        endcase
    end

    assign status.kind       = kind_reg;
    assign status.now_gt_end = gt_reg;
    assign status.gap_gt_len = (gap_reg > len_time);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg <= CFG_LEN_W'(1000000);
            report_reg  <= 1'b0;
            ws_reg      <= '0;
            idx_reg     <= NUMBER_W'(1);
            run_reg     <= '0;
            last_reg    <= '0;
            let_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_WINDOW_LENGTH:
                    begin
                        len_cfg_reg <= cfg_data[CFG_LEN_W-1:0];
                    end
                    CFG_FIRST_WINDOW_START:
                    begin
                        ws_reg  <= TIME_WIDTH'(cfg_data);
                        idx_reg <= NUMBER_W'(1);
                    end
                    CFG_REPORT_FULL_WINDOW:
                    begin
                        report_reg <= cfg_data[0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (cmd.step_end)
            begin
                ws_reg  <= end_reg;
                idx_reg <= idx_reg + NUMBER_W'(1);
            end
            else if (cmd.jump)
            begin
                // start + (q + 1) * len folds to now - remainder
                ws_reg  <= now_reg - TIME_WIDTH'(rem_reg);
                idx_reg <= idx_reg + NUMBER_W'(quo_reg) + NUMBER_W'(1);
            end
            if (cmd.classify)
            begin
                run_reg  <= run_next;
                last_reg <= last_next;
                let_reg  <= now_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            kind_reg  <= kind_t'(in_kind);
            now_reg   <= TIME_WIDTH'(in_now);
            value_reg <= in_value;
        end
        if (cmd.calc_end)
        begin
            end_reg <= ws_reg + len_time;
        end
        if (cmd.calc_gap)
        begin
            gap_reg <= now_reg - end_reg;
            gt_reg  <= (now_reg > end_reg);
        end
        if (cmd.div_load)
        begin
            quo_reg <= gap_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[TIME_WIDTH-2:0], q_bit};
            rem_reg <= rem_step;
        end
        if (cmd.calc_prev)
        begin
            prev_reg <= (ws_reg >= len_time) ? (ws_reg - len_time) : '0;
        end
        if (cmd.load_out)
        begin
            rep_reg <= COUNT_OUT_W'(report_reg ? last_reg : run_reg);
            wst_reg <= NOW_W'(ws_reg);
            num_reg <= idx_reg;
        end
    end

    assign reported_count    = rep_reg;
    assign window_start_time = wst_reg;
    assign window_number     = num_reg;

endmodule

// ===== src/twec_controller.sv =====
module twec_controller
    import twec_pkg::*;
#(
    parameter int TIME_WIDTH = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    output twec_cmd_t    cmd,
    input  twec_status_t status
);

    localparam int CNT_W = $clog2(TIME_WIDTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_END,
        S_CMP,
        S_GAP,
        S_DIV,
        S_JUMP,
        S_PREV,
        S_CLS,
        S_OUT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.latch_item = in_valid;
                if (in_valid)
                begin
                    state_next = S_END;
                end
            end
            S_END:
            begin
                cmd.calc_end = 1'b1;
                // read count leaves the window alone
                state_next = (status.kind == KIND_READ_COUNT) ? S_OUT : S_CMP;
            end
            S_CMP:
            begin
                cmd.calc_gap = 1'b1;
                state_next   = S_GAP;
            end
            S_GAP:
            begin
                if (!status.now_gt_end)
                begin
                    state_next = S_PREV;
                end
                else if (status.gap_gt_len)
                begin
                    cmd.div_load = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_DIV;
                end
                else
                begin
                    cmd.step_end = 1'b1;
                    state_next   = S_PREV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(TIME_WIDTH - 1))
                begin
                    state_next = S_JUMP;
                end
            end
            S_JUMP:
            begin
                cmd.jump   = 1'b1;
                state_next = S_PREV;
            end
            S_PREV:
            begin
                cmd.calc_prev = 1'b1;
                state_next = (status.kind == KIND_READ_INTERVAL) ? S_OUT : S_CLS;
            end
            S_CLS:
            begin
                cmd.classify = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== src/tumbling_window_event_counter.sv =====
// Tumbling-window event counter. Each transfer on the slave side carries an
// operation in s_tuser (add, set, read count, read interval) and a timestamp
// and value in s_tdata; each produces exactly one result on the master side
// with the reported count, the current window start and the window number.
// Items are processed one at a time; read count skips the window update and
// read interval skips the count update. When more than one window has been
// skipped the catch-up runs a one-bit-per-cycle restoring divider over the
// gap. A result is loaded only when the output register is empty or its
// result is being taken, and the next item is taken the cycle after the
// result is loaded. A finished result waits in the output register while
// the next item is taken.
// Configuration writes are accepted at any time but must only be issued while
// the block is idle; writing first_window_start also restarts the window
// number at one.
module tumbling_window_event_counter
    import twec_pkg::*;
#(
    parameter int TIME_WIDTH  = 64,
    parameter int COUNT_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // now_time[62:0], value[94:63]
    input  logic [KIND_W-1:0]      s_tuser,   // kind[1:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // reported_count[31:0], window_start_time[94:32], window_number[126:95]
    output logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    twec_cmd_t              cmd;
    twec_status_t           status;
    logic [COUNT_OUT_W-1:0] reported_count;
    logic [NOW_W-1:0]       window_start_time;
    logic [NUMBER_W-1:0]    window_number;

    assign cfg_ready = 1'b1;

    twec_controller #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .status    (status)
    );

    twec_datapath #(
        .TIME_WIDTH  (TIME_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .cfg_we            (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_kind           (s_tuser),
        .in_now            (s_tdata[NOW_W-1:0]),
        .in_value          (s_tdata[NOW_W+VALUE_W-1:NOW_W]),
        .reported_count    (reported_count),
        .window_start_time (window_start_time),
        .window_number     (window_number)
    );

    assign m_tdata = {1'b0, window_number, window_start_time, reported_count};

endmodule

// ===== src/twec_checker.sv =====
module twec_checker
    import twec_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // one item in flight: input closes after each transfer
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input still ready after transfer");

    // a result never appears the cycle after its item was taken
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result rose straight after input transfer");

    // a new result is loaded only as the controller returns to idle
    a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> s_tready)
        else $error("result raised while busy");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind tumbling_window_event_counter twec_checker u_twec_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/window_count_checker.sv =====
module window_count_checker
    import twec_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic [KIND_W-1:0]      s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int unsigned            fail_count,
    output int unsigned            pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    // same bit order as m_tdata: count lowest, window number highest
    typedef struct packed {
        logic [NUMBER_W-1:0]    number;
        logic [NOW_W-1:0]       start;
        logic [COUNT_OUT_W-1:0] count;
    } window_report_t;

    window_report_t expected_reports[$];

    logic [CFG_LEN_W-1:0]   length_reg;
    logic                   full_mode;
    logic [COUNT_OUT_W-1:0] running;
    logic [COUNT_OUT_W-1:0] last_full;
    logic [63:0]            last_event;
    logic [63:0]            win_start;
    logic [NUMBER_W-1:0]    win_number;
    int unsigned            fails = 0;

    function automatic window_report_t step_window(kind_t kind, logic [NOW_W-1:0] now,
                                                   logic [VALUE_W-1:0] value);
        logic [63:0]    span;
        logic [63:0]    win_end;
        logic [63:0]    gap;
        logic [63:0]    skips;
        logic [63:0]    prev_start;
        window_report_t rep;
        span = (length_reg == '0) ? 64'd1 : 64'(length_reg);
        if (kind != KIND_READ_COUNT)
        begin
            win_end = win_start + span;
            if (64'(now) > win_end)
            begin
                gap = 64'(now) - win_end;
                if (gap > span)
                begin
                    // several windows skipped: jump by whole lengths
                    skips      = gap / span + 64'd1;
                    win_start  = win_start + skips * span;
                    win_number = win_number + skips[NUMBER_W-1:0];
                end
                else
                begin
                    win_start  = win_end;
                    win_number = win_number + 32'd1;
                end
            end
        end
        if (kind == KIND_ADD || kind == KIND_SET)
        begin
            prev_start = (win_start >= span) ? win_start - span : 64'd0;
            if (last_event < prev_start)
            begin
                running   = '0;
                last_full = '0;
            end
            else if (last_event < win_start)
            begin
                last_full = running;
                running   = '0;
            end
            last_event = 64'(now);
            if (kind == KIND_ADD)
                running = running + value;
            else
            begin
                last_full = value;
                running   = '0;
            end
        end
        rep.count  = full_mode ? last_full : running;
        rep.start  = win_start[NOW_W-1:0];
        rep.number = win_number;
        return rep;
    endfunction

    function void note_mismatch(string field, logic [63:0] want, logic [63:0] got);
        fails++;
        $display("%0t: %s expected %h, got %h", $time, field, want, got);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        window_report_t got;
        window_report_t want;
        if (!rst_n)
        begin
            length_reg = 40'd1000000;
            full_mode  = 1'b0;
            running    = '0;
            last_full  = '0;
            last_event = '0;
            win_start  = '0;
            win_number = 32'd1;
            expected_reports.delete();
            pending_results <= 0;
            fail_count      <= fails;
        end
        else
        begin
            // results first: a result can never belong to an item taken at the same edge
            if (m_tvalid && m_tready)
            begin
                got = window_report_t'(m_tdata[$bits(window_report_t)-1:0]);
                if (expected_reports.size() == 0)
                begin
                    fails++;
                    $display("%0t: result with nothing expected, expected none, got %h",
                             $time, m_tdata);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (got.count !== want.count)
                        note_mismatch("reported_count", 64'(want.count), 64'(got.count));
                    if (got.start !== want.start)
                        note_mismatch("window_start_time", 64'(want.start), 64'(got.start));
                    if (got.number !== want.number)
                        note_mismatch("window_number", 64'(want.number), 64'(got.number));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_WINDOW_LENGTH:      length_reg = cfg_data[CFG_LEN_W-1:0];
                    CFG_FIRST_WINDOW_START:
                    begin
                        win_start  = 64'(cfg_data);
                        win_number = 32'd1;
                    end
                    CFG_REPORT_FULL_WINDOW: full_mode = cfg_data[0];
                    default:                ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_reports.insert(expected_reports.size(),
                                        step_window(kind_t'(s_tuser),
                                                    s_tdata[NOW_W-1:0],
                                                    s_tdata[NOW_W+VALUE_W-1:NOW_W]));
            pending_results <= expected_reports.size();
            fail_count      <= fails;
        end
    end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import twec_pkg::*;

    localparam logic [NOW_W-1:0]       TIME_MAX    = {NOW_W{1'b1}};
    localparam logic [CFG_LEN_W-1:0]   LENGTH_MAX  = {CFG_LEN_W{1'b1}};
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE   = 2'd3;  // decodes to no register
    localparam int unsigned            LONG_HOLD   = 500;
    localparam int                     PHASES      = 10;
    localparam int                     PHASE_ITEMS = 185;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [KIND_W-1:0]      s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int unsigned            fail_count;
    int unsigned            pending_results;

    logic                   hold_req = 1'b0;
    logic                   rx_gaps = 1'b1;
    bit                     tx_gaps = 1'b1;
    logic [NOW_W-1:0]       cursor = '0;
    logic [CFG_LEN_W-1:0]   len_set = 40'd1000000;

    tumbling_window_event_counter u_top (.*);

    window_count_checker u_checker (.*);

    always #5 clk = ~clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly back-to-back, sometimes a few cycles, rarely a long gap
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 16);
        return $urandom_range(30, 80);
    endfunction

    function automatic kind_t pick_kind();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return KIND_ADD;
        else if (r < 62)
            return KIND_SET;
        else if (r < 80)
            return KIND_READ_COUNT;
        return KIND_READ_INTERVAL;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'd0;
            4:       return 32'($urandom_range(0, 16)) - 32'd8;
            default: return $urandom;
        endcase
    endfunction

    // event time: mostly moving forward through the windows, some stepping back
    function automatic logic [NOW_W-1:0] pick_time();
        logic [63:0] span;
        logic [63:0] t;
        int unsigned r;
        span = (len_set == '0) ? 64'd1 : 64'(len_set);
        t    = 64'(cursor);
        r    = $urandom_range(0, 99);
        if (r < 45)
            t = t + rand64() % (span / 4 + 64'd1);
        else if (r < 65)
            t = t + span + rand64() % span;
        else if (r < 78)
            t = t + span * $urandom_range(2, 40) + rand64() % span;
        else if (r < 84)
            t = t + span;
        else if (r < 88)
            t = t + (rand64() >> $urandom_range(2, 40));
        else if (r < 94)
            t = (t > span * 2) ? t - rand64() % (span * 2) : 64'd0;
        else
            return NOW_W'(rand64());
        if (t > 64'(TIME_MAX))
            t = 64'(TIME_MAX);
        cursor = t[NOW_W-1:0];
        return cursor;
    endfunction

    task automatic send_item(input kind_t kind, input logic [NOW_W-1:0] at,
                             input logic [VALUE_W-1:0] val);
        int unsigned gap;
        gap = tx_gaps ? idle_len() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom, $urandom};
            s_tuser  <= KIND_W'($urandom);
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, val, at};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
    endtask

    // leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic configure(input logic [CFG_LEN_W-1:0] len, input logic [NOW_W-1:0] start,
                             input bit set_start, input bit full);
        logic [CFG_DATA_W-1:0] junk;
        junk = $urandom_range(0, 1) ? CFG_DATA_W'(rand64()) : '0;
        write_reg(CFG_WINDOW_LENGTH, {junk[CFG_DATA_W-1:CFG_LEN_W], len});
        if (set_start)
        begin
            write_reg(CFG_FIRST_WINDOW_START, start);
            cursor = start;
        end
        write_reg(CFG_REPORT_FULL_WINDOW, {junk[CFG_DATA_W-1:1], full});
        cfg_valid <= 1'b0;
        len_set = len;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req   <= 1'b0;
                m_tready   <= 1'b0;
                stall_left = LONG_HOLD;
            end
            else if (stall_left > 0)
                stall_left--;
            else if (rx_gaps && $urandom_range(0, 3) == 0)
            begin
                m_tready   <= 1'b0;
                stall_left = idle_len();
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        int                   p;
        int                   n;
        logic [CFG_LEN_W-1:0] len;
        logic [NOW_W-1:0]     start;
        bit                   full;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = KIND_ADD;
        cfg_valid = 1'b0;
        cfg_index = CFG_WINDOW_LENGTH;
        cfg_data  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: length 1000000, first window at 0, running count reported
        send_item(KIND_READ_COUNT, 63'd0, 32'd0);
        send_item(KIND_ADD, 63'd10, 32'd5);
        send_item(KIND_ADD, 63'd20, 32'hFFFF_FFFF);
        send_item(KIND_ADD, 63'd999_999, 32'h7FFF_FFFF);
        send_item(KIND_READ_INTERVAL, 63'd1_000_000, 32'hFFFF_FFFF);  // on the boundary
        send_item(KIND_ADD, 63'd1_000_001, 32'h8000_0000);            // one window on
        send_item(KIND_SET, 63'd1_500_000, 32'hDEAD_BEEF);
        send_item(KIND_READ_COUNT, TIME_MAX, 32'd0);                  // must not advance
        send_item(KIND_ADD, 63'd4_200_000, 32'd3);                    // skip, counts cleared
        send_item(KIND_READ_INTERVAL, TIME_MAX, 32'd0);               // huge jump
        send_item(KIND_ADD, 63'd7, 32'd1);                            // event in the past
        wait_drained();

        // zero length counts as one
        write_reg(CFG_SPARE, CFG_DATA_W'(rand64()));
        configure(40'd0, 63'd0, 1'b1, 1'b1);
        send_item(KIND_ADD, 63'd0, 32'd9);
        send_item(KIND_ADD, 63'd1, 32'd2);
        send_item(KIND_ADD, 63'd2, 32'd4);
        send_item(KIND_SET, 63'd10, 32'd1);
        send_item(KIND_READ_COUNT, 63'd3, 32'd0);
        wait_drained();

        // longest window starting at the very end of time
        configure(LENGTH_MAX, TIME_MAX, 1'b1, 1'b0);
        send_item(KIND_ADD, TIME_MAX, 32'h7FFF_FFFF);
        send_item(KIND_READ_INTERVAL, 63'd0, 32'd0);
        send_item(KIND_SET, 63'd12345, 32'hFFFF_FFFF);
        wait_drained();

        // start below one length: the older-window test cannot fire before the jump to TIME_MAX
        configure(LENGTH_MAX, 63'd0, 1'b1, 1'b1);
        send_item(KIND_ADD, 63'd5, 32'd1);
        send_item(KIND_ADD, 63'h100_0000_000A, 32'd2);
        send_item(KIND_ADD, TIME_MAX, 32'd3);

        for (p = 0; p < PHASES; p++)
        begin
            wait_drained();
            case (p)
                0:       len = 40'd1;
                1:       len = LENGTH_MAX;
                2:       len = 40'd0;
                default:
                    case ($urandom_range(0, 2))
                        0:       len = 40'($urandom_range(2, 64));
                        1:       len = 40'($urandom_range(100, 100000));
                        default: len = CFG_LEN_W'(rand64());
                    endcase
            endcase
            if (p % 3 == 0)
                start = '0;
            else if (p == 7)
                start = TIME_MAX - 63'($urandom_range(0, 1000));
            else
                start = NOW_W'(rand64());
            full = (p < 2) ? bit'(p) : bit'($urandom_range(0, 1));
            // phase 5 keeps the window position from the phase before
            configure(len, start, p != 5, full);
            tx_gaps = !(p == 2 || p == 6 || p == 8);
            rx_gaps <= (p != 3 && p != 8);
            if (p == 2 || p == 6)
                hold_req <= 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 4 && n == PHASE_ITEMS / 2)
                    wait_drained();
                send_item(pick_kind(), pick_time(), pick_value());
            end
        end

        wait_drained();
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
